FILE: rtl/dfq_pkg.sv
// Shared types and constants for the duplicate-rejecting FIFO queue.
// Used by the queue core and its port checker; depends on nothing.
package dfq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int CMD_W = 3;
  localparam int ST_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE    = 3'd0,
    CMD_DEQUEUE    = 3'd1,
    CMD_LIST       = 3'd2,
    CMD_LIST_CLEAR = 3'd3,
    CMD_CLEAR      = 3'd4
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_FULL    = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_DEQ    = 4'b0100,
    S_LIST   = 4'b1000
  } state_t;

  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

endpackage

FILE: rtl/dfq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependencies.
module dfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/dedup_fifo_queue_core.sv
// Duplicate-rejecting FIFO queue of 32-bit identifiers, top level.
// Uses dfq_pkg and dfq_ram for the entry store.
// Enqueue reads the store one entry per cycle for the duplicate search, then makes the last
// compare and the decision; into an empty queue it writes the entry directly. Dequeue reads
// the head entry; list gives one result per cycle unless the result is stalled; clear needs no store read.
// A new request is taken once the last result has left.
// Reset (synchronous) empties the queue; the entry store itself is not cleared.
module dedup_fifo_queue_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  logic [dfq_pkg::CMD_W-1:0]    command,
  input  logic [dfq_pkg::VAL_W-1:0]    record_value,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [dfq_pkg::ST_W-1:0]     status,
  output logic [dfq_pkg::VAL_W-1:0]    entry_value,
  output logic                         last_of_run
);

  dfq_pkg::state_t             state;
  logic [dfq_pkg::IDX_W-1:0]   head;
  logic [dfq_pkg::IDX_W-1:0]   tail;
  logic [dfq_pkg::CNT_W-1:0]   count;
  logic [dfq_pkg::IDX_W-1:0]   ptr;
  logic [dfq_pkg::CNT_W-1:0]   iss;
  logic                        rd_pend;
  logic                        clr_after;
  logic [dfq_pkg::VAL_W-1:0]   val_q;
  dfq_pkg::status_t            res_status;
  logic [dfq_pkg::VAL_W-1:0]   res_value;
  logic                        res_last;
  logic                        res_valid_q;

  logic                        cmd_fire;
  logic                        res_free;
  logic                        issue;
  logic                        search_hit;
  logic                        search_done;
  logic                        last_item;
  logic                        is_full;
  logic                        ram_we;
  logic [dfq_pkg::IDX_W-1:0]   ram_waddr;
  logic [dfq_pkg::VAL_W-1:0]   ram_wdata;
  logic                        ram_re;
  logic [dfq_pkg::IDX_W-1:0]   ram_raddr;
  logic [dfq_pkg::VAL_W-1:0]   ram_rdata;

  assign cmd_ready   = (state == dfq_pkg::S_IDLE) && !res_valid;
  assign cmd_fire    = cmd_valid && cmd_ready;
  assign res_free    = !res_valid || res_ready;
  assign issue       = (state == dfq_pkg::S_SEARCH) && (iss < count);
  assign search_hit  = rd_pend && (ram_rdata == val_q);
  assign search_done = !rd_pend && (iss == count);
  assign last_item   = ((iss + dfq_pkg::CNT_W'(1)) == count);
  assign is_full     = (count == dfq_pkg::CNT_W'(dfq_pkg::QUEUE_DEPTH));

  assign res_valid   = res_valid_q;
  assign status      = res_status;
  assign entry_value = res_value;
  assign last_of_run = res_last;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = ptr;
    ram_we    = 1'b0;
    ram_waddr = tail;
    ram_wdata = val_q;
    unique case (state)
      dfq_pkg::S_IDLE: begin
        ram_wdata = record_value;
        if (cmd_fire && (count != '0)) begin
          if ((command == dfq_pkg::CMD_DEQUEUE) || (command == dfq_pkg::CMD_LIST) ||
              (command == dfq_pkg::CMD_LIST_CLEAR)) begin
            ram_re    = 1'b1;
            ram_raddr = head;
          end
        end
        if (cmd_fire && (count == '0) && (command == dfq_pkg::CMD_ENQUEUE)) begin
          ram_we = 1'b1;
        end
      end
      dfq_pkg::S_SEARCH: begin
        ram_re = issue;
        if (!search_hit && search_done && !is_full) begin
          ram_we = 1'b1;
        end
      end
      dfq_pkg::S_LIST: begin
        if (res_free && !last_item) begin
          ram_re    = 1'b1;
          ram_raddr = dfq_pkg::wrap_next(ptr);
        end
      end
      default: begin
      end
    endcase
  end

  dfq_ram #(
    .WIDTH(dfq_pkg::VAL_W),
    .DEPTH(dfq_pkg::QUEUE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= dfq_pkg::S_IDLE;
      head        <= '0;
      tail        <= '0;
      count       <= '0;
      ptr         <= '0;
      iss         <= '0;
      rd_pend     <= 1'b0;
      clr_after   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (res_valid_q && res_ready) begin
        res_valid_q <= 1'b0;
      end
      unique case (state)
        dfq_pkg::S_IDLE: begin
          rd_pend <= 1'b0;
          if (cmd_fire) begin
            val_q     <= record_value;
            clr_after <= (command == dfq_pkg::CMD_LIST_CLEAR);
            ptr       <= head;
            iss       <= '0;
            unique case (command)
              dfq_pkg::CMD_ENQUEUE: begin
                if (count == '0) begin
                  tail        <= dfq_pkg::wrap_next(tail);
                  count       <= dfq_pkg::CNT_W'(1);
                  res_valid_q <= 1'b1;
                  res_status  <= dfq_pkg::ST_OK;
                  res_value   <= '0;
                  res_last    <= 1'b1;
                end else begin
                  state <= dfq_pkg::S_SEARCH;
                end
              end
              dfq_pkg::CMD_DEQUEUE: begin
                if (count == '0) begin
                  res_valid_q <= 1'b1;
                  res_status  <= dfq_pkg::ST_EMPTY;
                  res_value   <= '0;
                  res_last    <= 1'b1;
                end else begin
                  state <= dfq_pkg::S_DEQ;
                end
              end
              dfq_pkg::CMD_LIST, dfq_pkg::CMD_LIST_CLEAR: begin
                if (count == '0) begin
                  res_valid_q <= 1'b1;
                  res_status  <= dfq_pkg::ST_EMPTY;
                  res_value   <= '0;
                  res_last    <= 1'b1;
                  if (command == dfq_pkg::CMD_LIST_CLEAR) begin
                    head <= '0;
                    tail <= '0;
                  end
                end else begin
                  state <= dfq_pkg::S_LIST;
                end
              end
              dfq_pkg::CMD_CLEAR: begin
                res_valid_q <= 1'b1;
                res_status  <= (count != '0) ? dfq_pkg::ST_CLEARED : dfq_pkg::ST_OK;
                res_value   <= '0;
                res_last    <= 1'b1;
                head        <= '0;
                tail        <= '0;
                count       <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        dfq_pkg::S_SEARCH: begin
          rd_pend <= issue;
          if (issue) begin
            ptr <= dfq_pkg::wrap_next(ptr);
            iss <= iss + 1'b1;
          end
          if (search_hit) begin
            state       <= dfq_pkg::S_IDLE;
            res_valid_q <= 1'b1;
            res_status  <= dfq_pkg::ST_DUP;
            res_value   <= '0;
            res_last    <= 1'b1;
          end else if (search_done) begin
            state       <= dfq_pkg::S_IDLE;
            res_valid_q <= 1'b1;
            res_value   <= '0;
            res_last    <= 1'b1;
            if (is_full) begin
              res_status <= dfq_pkg::ST_FULL;
            end else begin
              res_status <= dfq_pkg::ST_OK;
              tail       <= dfq_pkg::wrap_next(tail);
              count      <= count + 1'b1;
            end
          end
        end
        dfq_pkg::S_DEQ: begin
          state       <= dfq_pkg::S_IDLE;
          res_valid_q <= 1'b1;
          res_status  <= dfq_pkg::ST_OK;
          res_value   <= ram_rdata;
          res_last    <= 1'b1;
          head        <= dfq_pkg::wrap_next(head);
          count       <= count - 1'b1;
        end
        dfq_pkg::S_LIST: begin
          if (res_free) begin
            res_valid_q <= 1'b1;
            res_status  <= dfq_pkg::ST_OK;
            res_value   <= ram_rdata;
            res_last    <= last_item;
            ptr         <= dfq_pkg::wrap_next(ptr);
            iss         <= iss + 1'b1;
            if (last_item) begin
              state <= dfq_pkg::S_IDLE;
              if (clr_after) begin
                head  <= '0;
                tail  <= '0;
                count <= '0;
              end
            end
          end
        end
        default: begin
          state <= dfq_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/dfq_checker.sv
// Port-level checker for the duplicate-rejecting FIFO queue core.
// Uses dfq_pkg; bound to dedup_fifo_queue_core at the end of this file.
module dfq_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cmd_valid,
  input logic                         cmd_ready,
  input logic [dfq_pkg::CMD_W-1:0]    command,
  input logic [dfq_pkg::VAL_W-1:0]    record_value,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [dfq_pkg::ST_W-1:0]     status,
  input logic [dfq_pkg::VAL_W-1:0]    entry_value,
  input logic                         last_of_run
);

  // A stalled result keeps its payload.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status) && $stable(entry_value) &&
                                $stable(last_of_run))
    else $error("result changed while stalled");

  // A new request is never taken while a result is still waiting.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    cmd_ready |-> !res_valid)
    else $error("request taken while a result is pending");

  // After a known command is taken, ready is low in the next cycle.
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (command <= dfq_pkg::CMD_CLEAR) |=> !cmd_ready)
    else $error("ready directly after a known request");

  // Every status other than ok ends the run and carries no identifier.
  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status != dfq_pkg::ST_OK) |-> last_of_run && (entry_value == '0))
    else $error("non-ok result with identifier or without last marker");

endmodule

bind dedup_fifo_queue_core dfq_checker u_dfq_checker (.*);

FILE: verif/tb_dedup_fifo_queue_core.sv
// Testbench for dedup_fifo_queue_core: directed and random requests checked against a
// built-in shadow of the duplicate-rejecting queue. Depends on rtl/dfq_pkg.sv and the core.
module tb_dedup_fifo_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int POOL_SIZE = 24;

  typedef struct {
    dfq_pkg::status_t          st;
    logic [dfq_pkg::VAL_W-1:0] value;
    logic                      last;
  } response_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cmd_valid = 1'b0;
  logic                      cmd_ready;
  logic [dfq_pkg::CMD_W-1:0] command = '0;
  logic [dfq_pkg::VAL_W-1:0] record_value = '0;
  logic                      res_valid;
  logic                      res_ready = 1'b0;
  logic [dfq_pkg::ST_W-1:0]  status;
  logic [dfq_pkg::VAL_W-1:0] entry_value;
  logic                      last_of_run;

  logic [dfq_pkg::VAL_W-1:0] shadow_store [dfq_pkg::QUEUE_DEPTH];
  int                        shadow_head = 0;
  int                        shadow_tail = 0;
  int                        shadow_count = 0;
  response_t                 pending_responses [$];
  int                        error_count = 0;
  int                        idle_cycles = 0;
  int                        send_idle_pct = 0;
  int                        recv_idle_pct = 0;

  dedup_fifo_queue_core DUT (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .command      (command),
    .record_value (record_value),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .status       (status),
    .entry_value  (entry_value),
    .last_of_run  (last_of_run)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic push_response(input dfq_pkg::status_t st,
                               input logic [dfq_pkg::VAL_W-1:0] value, input logic last);
    response_t r;
    r.st = st;
    r.value = value;
    r.last = last;
    pending_responses.push_back(r);
  endtask

  task automatic emit_listing();
    int idx;
    idx = shadow_head;
    if (shadow_count == 0) begin
      push_response(dfq_pkg::ST_EMPTY, '0, 1'b1);
    end else begin
      for (int n = 0; n < shadow_count; n++) begin
        push_response(dfq_pkg::ST_OK, shadow_store[idx], n == shadow_count - 1);
        idx = (idx + 1) % dfq_pkg::QUEUE_DEPTH;
      end
    end
  endtask

  task automatic predict_queue_response(input logic [dfq_pkg::CMD_W-1:0] cmd,
                                        input logic [dfq_pkg::VAL_W-1:0] value);
    bit found;
    int idx;
    found = 1'b0;
    idx = shadow_head;
    case (cmd)
      dfq_pkg::CMD_ENQUEUE: begin
        for (int n = 0; n < shadow_count; n++) begin
          if (shadow_store[idx] == value) found = 1'b1;
          idx = (idx + 1) % dfq_pkg::QUEUE_DEPTH;
        end
        if (found) begin
          push_response(dfq_pkg::ST_DUP, '0, 1'b1);
        end else if (shadow_count >= dfq_pkg::QUEUE_DEPTH) begin
          push_response(dfq_pkg::ST_FULL, '0, 1'b1);
        end else begin
          shadow_store[shadow_tail] = value;
          shadow_tail = (shadow_tail + 1) % dfq_pkg::QUEUE_DEPTH;
          shadow_count++;
          push_response(dfq_pkg::ST_OK, '0, 1'b1);
        end
      end
      dfq_pkg::CMD_DEQUEUE: begin
        if (shadow_count == 0) begin
          push_response(dfq_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          push_response(dfq_pkg::ST_OK, shadow_store[shadow_head], 1'b1);
          shadow_head = (shadow_head + 1) % dfq_pkg::QUEUE_DEPTH;
          shadow_count--;
        end
      end
      dfq_pkg::CMD_LIST: begin
        emit_listing();
      end
      dfq_pkg::CMD_LIST_CLEAR: begin
        emit_listing();
        shadow_head = 0;
        shadow_tail = 0;
        shadow_count = 0;
      end
      dfq_pkg::CMD_CLEAR: begin
        push_response((shadow_count != 0) ? dfq_pkg::ST_CLEARED : dfq_pkg::ST_OK, '0, 1'b1);
        shadow_head = 0;
        shadow_tail = 0;
        shadow_count = 0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_request(input logic [dfq_pkg::CMD_W-1:0] cmd,
                              input logic [dfq_pkg::VAL_W-1:0] value);
    int gaps;
    gaps = 0;
    while ($urandom_range(99) < send_idle_pct) gaps++;
    if (gaps > 0) begin
      cmd_valid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    command <= cmd;
    record_value <= value;
    do @(posedge clk); while (!cmd_ready);
    predict_queue_response(cmd, value);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      idle_cycles <= 0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_idle_pct);
      if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (res_valid && res_ready) begin
        if (pending_responses.size() == 0) begin
          $error("unexpected result: status %0d, entry_value %h, last_of_run %b",
                 status, entry_value, last_of_run);
          error_count++;
        end else begin
          response_t exp_r;
          exp_r = pending_responses.pop_front();
          if (status !== exp_r.st) begin
            $error("status mismatch: expected %0d, actual %0d", exp_r.st, status);
            error_count++;
          end
          if (entry_value !== exp_r.value) begin
            $error("entry_value mismatch: expected %h, actual %h", exp_r.value, entry_value);
            error_count++;
          end
          if (last_of_run !== exp_r.last) begin
            $error("last_of_run mismatch: expected %b, actual %b", exp_r.last, last_of_run);
            error_count++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("dedup_fifo_queue_core verification failed");
        $finish;
      end
    end
  end

  task automatic test_empty_queue();
    send_request(dfq_pkg::CMD_DEQUEUE, $urandom);
    send_request(dfq_pkg::CMD_LIST, $urandom);
    send_request(dfq_pkg::CMD_LIST_CLEAR, $urandom);
    send_request(dfq_pkg::CMD_CLEAR, $urandom);
  endtask

  task automatic test_unknown_commands();
    for (int c = dfq_pkg::CMD_CLEAR + 1; c < (1 << dfq_pkg::CMD_W); c++) begin
      send_request(dfq_pkg::CMD_W'(c), $urandom);
    end
  endtask

  task automatic test_fill_to_full();
    send_request(dfq_pkg::CMD_ENQUEUE, '0);
    send_request(dfq_pkg::CMD_ENQUEUE, '1);
    for (int i = 2; i < dfq_pkg::QUEUE_DEPTH; i++) begin
      send_request(dfq_pkg::CMD_ENQUEUE,
                   dfq_pkg::VAL_W'($urandom_range(32'hFFFF_FFFE, 1)));
    end
    send_request(dfq_pkg::CMD_ENQUEUE, 32'h5A5A_A5A5);
    send_request(dfq_pkg::CMD_ENQUEUE, '0);
    send_request(dfq_pkg::CMD_LIST, '0);
  endtask

  task automatic test_duplicate_and_clear();
    send_request(dfq_pkg::CMD_DEQUEUE, '0);
    send_request(dfq_pkg::CMD_ENQUEUE, '1);
    send_request(dfq_pkg::CMD_LIST_CLEAR, '0);
    send_request(dfq_pkg::CMD_ENQUEUE, 32'h1234_5678);
    send_request(dfq_pkg::CMD_CLEAR, '0);
  endtask

  task automatic test_random_traffic(input int num_requests);
    logic [dfq_pkg::VAL_W-1:0] id_pool [POOL_SIZE];
    logic [dfq_pkg::VAL_W-1:0] value;
    int sent;
    int pick;
    sent = 0;
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = $urandom;
    id_pool[0] = '0;
    id_pool[1] = '1;
    while (sent < num_requests) begin
      value = ($urandom_range(99) < 60) ? id_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_request(dfq_pkg::CMD_ENQUEUE, value);
      end else if (pick < 70) begin
        send_request(dfq_pkg::CMD_DEQUEUE, value);
      end else if (pick < 80) begin
        send_request(dfq_pkg::CMD_LIST, value);
      end else if (pick < 86) begin
        send_request(dfq_pkg::CMD_LIST_CLEAR, value);
      end else if (pick < 92) begin
        send_request(dfq_pkg::CMD_CLEAR, value);
      end else begin
        send_request(dfq_pkg::CMD_W'($urandom_range((1 << dfq_pkg::CMD_W) - 1,
                                                    dfq_pkg::CMD_CLEAR + 1)), value);
        sent--;
      end
      sent++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 78;
    test_empty_queue();
    test_unknown_commands();
    test_fill_to_full();
    test_duplicate_and_clear();
    test_random_traffic(25);
    send_idle_pct = 78;
    recv_idle_pct = 7;
    test_random_traffic(25);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(25);
    cmd_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (dfq_pkg::QUEUE_DEPTH + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("dedup_fifo_queue_core verification clean");
    end else begin
      $display("dedup_fifo_queue_core verification failed");
    end
    $finish;
  end

endmodule
